/* hw/rtl/ecgrp_pkg.sv */
// ----------------------------------------------------------------------------
// ecgrp_pkg
// Shared constants and types of the ECG R-peak / heart-rate detector.
// ----------------------------------------------------------------------------
package ecgrp_pkg;

	// default structure parameters
	localparam int DEF_WINDOW      = 320;
	localparam int DEF_SAMPLE_BITS = 10;
	localparam int DEF_AVG_BEATS   = 3;

	// fixed field widths
	localparam int TICK_W     = 32;
	localparam int RATE_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// serial divider: dividend width (ticks per minute)
	localparam int DIV_N = 24;

	// consecutive bad rates that force the heart rate to zero
	localparam logic [1:0] BAD_LIMIT = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY_TICKS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MINUTE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NO_BEAT_TICKS    = 3'd6;

	// configuration reset values
	localparam logic [9:0]  RST_WINDOW_TOP       = 10'd0;
	localparam logic [9:0]  RST_WINDOW_HEIGHT    = 10'd1023;
	localparam logic [15:0] RST_REFRACTORY_TICKS = 16'd400;
	localparam logic [23:0] RST_TICKS_PER_MINUTE = 24'd60000;
	localparam logic [7:0]  RST_MIN_RATE         = 8'd50;
	localparam logic [7:0]  RST_MAX_RATE         = 8'd120;
	localparam logic [31:0] RST_NO_BEAT_TICKS    = 32'd20000;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* hw/rtl/ecgrp_ram.sv */
// ----------------------------------------------------------------------------
// ecgrp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ecgrp_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 320,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/ecgrp_div.sv */
// ----------------------------------------------------------------------------
// ecgrp_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ecgrp_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [ecgrp_pkg::DIV_N-1:0]        dividend,
	input  logic [ecgrp_pkg::TICK_W-1:0]       divisor,
	output logic [ecgrp_pkg::DIV_N-1:0]        quotient,
	output ecgrp_pkg::div_stat_t               stat
);

	localparam int N     = ecgrp_pkg::DIV_N;
	localparam int W     = ecgrp_pkg::TICK_W;
	localparam int CNT_W = $clog2(N);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N - 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W-1:0]     rem_q;
	logic [N-1:0]     dvd_q;
	logic [W-1:0]     dsr_q;

	logic [W:0]   rem_sh;
	logic         qbit;
	logic [W-1:0] rem_nx;

	// one trial subtraction
	always_comb begin
		rem_sh = {rem_q, dvd_q[N-1]};
		qbit   = (rem_sh >= {1'b0, dsr_q});
		rem_nx = qbit ? W'(rem_sh - {1'b0, dsr_q}) : rem_sh[W-1:0];
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_LAST;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[N-2:0], qbit};
		end
	end

	assign quotient  = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* hw/rtl/ecg_r_peak_heart_rate.sv */
// ----------------------------------------------------------------------------
// ecg_r_peak_heart_rate
// R-peak detector on a moving-average threshold with heart-rate averaging.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one transaction per ECG sample (display row) with its tick
//   count; m_* returns exactly one result per sample: clamped threshold,
//   beat, beat_rate_ok, rate_updated, averaged rate and no_beat.
//   cfg_* writes one register per transaction (index, data); cfg_ready is
//   always high. Write only while no sample is in flight.
// Sequencing:
//   one sample at a time. A beat adds a serial rate division, and a beat
//   that closes an average adds the averaging multiply. The sample ring
//   lives in a RAM with registered read data.
// Reset:
//   arst_n clears all control state and loads register defaults. The ring is not
//   cleared; until its first lap completes, the evicted sample reads as zero.
// Stall:
//   results sit in an output register; the next sample is accepted while a
//   result waits, and processing holds at the final step until m_tready.
// ----------------------------------------------------------------------------
module ecg_r_peak_heart_rate #(
	parameter int WINDOW      = ecgrp_pkg::DEF_WINDOW,
	parameter int SAMPLE_BITS = ecgrp_pkg::DEF_SAMPLE_BITS,
	parameter int AVG_BEATS   = ecgrp_pkg::DEF_AVG_BEATS,
	localparam int IN_W  = ((SAMPLE_BITS + ecgrp_pkg::TICK_W + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_BITS + ecgrp_pkg::RATE_W + 4 + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// low to high: sample, tick_now, zero fill
	input  logic [IN_W-1:0]                     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// low to high: threshold, beat, beat_rate_ok, rate_updated, avg_rate,
	// no_beat, zero fill
	output logic [OUT_W-1:0]                    m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ecgrp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ecgrp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int TW     = ecgrp_pkg::TICK_W;
	localparam int RW     = ecgrp_pkg::RATE_W;
	localparam int N      = ecgrp_pkg::DIV_N;
	localparam int IDX_W  = $clog2(WINDOW);
	localparam int SUM_W  = SAMPLE_BITS + IDX_W;
	// sum / WINDOW as an exact reciprocal multiplication
	localparam int AVG_SHIFT = SUM_W + IDX_W;
	localparam int AVG_MUL_W = SUM_W + 1;
	localparam logic [63:0] AVG_MUL_L =
		((64'd1 << AVG_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [AVG_MUL_W-1:0] AVG_MUL = AVG_MUL_L[AVG_MUL_W-1:0];
	// (7 * avg) / 10 as an exact reciprocal multiplication
	localparam int S7_W      = SAMPLE_BITS + 3;
	localparam int TEN_SHIFT = S7_W + 4;
	localparam int TEN_MUL_W = S7_W + 1;
	localparam logic [63:0] TEN_MUL_L = ((64'd1 << TEN_SHIFT) + 64'd9) / 64'd10;
	localparam logic [TEN_MUL_W-1:0] TEN_MUL = TEN_MUL_L[TEN_MUL_W-1:0];
	localparam int THR_W = (SAMPLE_BITS > 11) ? SAMPLE_BITS : 11;
	localparam int ACC_W = RW + $clog2(AVG_BEATS);
	localparam int CNT_W = $clog2(AVG_BEATS + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVG_BEATS - 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);
	// rate sum / AVG_BEATS as an exact reciprocal multiplication
	localparam int HAVG_SHIFT = ACC_W + $clog2(AVG_BEATS);
	localparam int HAVG_MUL_W = ACC_W + 1;
	localparam logic [63:0] HAVG_MUL_L =
		((64'd1 << HAVG_SHIFT) + 64'(AVG_BEATS) - 64'd1) / 64'(AVG_BEATS);
	localparam logic [HAVG_MUL_W-1:0] HAVG_MUL = HAVG_MUL_L[HAVG_MUL_W-1:0];

	// sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SUM   = 4'd1;
	localparam logic [3:0] ST_AVG   = 4'd2;
	localparam logic [3:0] ST_SCALE = 4'd3;
	localparam logic [3:0] ST_TEN   = 4'd4;
	localparam logic [3:0] ST_CLAMP = 4'd5;
	localparam logic [3:0] ST_RATE  = 4'd6;
	localparam logic [3:0] ST_HAVG  = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	// configuration registers
	logic [9:0]  top_q;
	logic [9:0]  height_q;
	logic [15:0] refr_q;
	logic [23:0] tpm_q;
	logic [7:0]  min_q;
	logic [7:0]  max_q;
	logic [31:0] nb_ticks_q;

	// control state
	logic [3:0]       state_q;
	logic [IDX_W-1:0] idx_q;
	logic             wrapped_q;
	logic [SUM_W-1:0] sum_q;
	logic [TW-1:0]    last_beat_q;
	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       bad_q;
	logic [RW-1:0]    rate_reg_q;
	logic             m_tvalid_q;

	// per-sample working registers
	logic [SAMPLE_BITS-1:0]         sample_q;
	logic [TW-1:0]                  tick_q;
	logic [TW-1:0]                  elapsed_q;
	logic [SUM_W+AVG_MUL_W-1:0]     prod_avg_q;
	logic [S7_W-1:0]                avg7_q;
	logic [S7_W+TEN_MUL_W-1:0]      prod_ten_q;
	logic [SAMPLE_BITS-1:0]         thr_q;
	logic                           beat_q;
	logic                           ok_q;
	logic                           upd_q;
	logic                           nobeat_q;
	logic [ACC_W-1:0]               avg_sum_q;
	logic [OUT_W-1:0]               m_tdata_q;

	// datapath signals
	logic                   accept;
	logic                   out_load;
	logic [SAMPLE_BITS-1:0] rd_data;
	logic [SAMPLE_BITS-1:0] old_sample;
	logic [SUM_W-1:0]       sum_next;
	logic [SAMPLE_BITS-1:0] avg_w;
	logic [SAMPLE_BITS-1:0] thr_raw;
	logic [10:0]            upper;
	logic [THR_W-1:0]       thr_lo;
	logic [THR_W-1:0]       thr_c;
	logic                   beat_w;
	logic [RW-1:0]          rate_sat;
	logic                   rate_ok;
	logic [ACC_W-1:0]       acc_next;
	logic [1:0]             bad_next;
	logic                   avg_full;
	logic [ACC_W+HAVG_MUL_W-1:0] havg_prod;
	logic                   div_start;
	logic [N-1:0]           div_dividend;
	logic [TW-1:0]          div_divisor;
	logic [N-1:0]           div_quot;
	ecgrp_pkg::div_stat_t   div_stat;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// sample ring
	ecgrp_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (state_q == ST_SUM),
		.waddr (idx_q),
		.wdata (sample_q),
		.re    (accept),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	// serial divider for the beat rate
	ecgrp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	// window sum and threshold arithmetic
	always_comb begin
		old_sample = wrapped_q ? rd_data : '0;
		sum_next   = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
		avg_w      = prod_avg_q[AVG_SHIFT +: SAMPLE_BITS];
		thr_raw    = prod_ten_q[TEN_SHIFT +: SAMPLE_BITS];
		upper      = {1'b0, top_q} + {1'b0, height_q};
		thr_lo     = (THR_W'(thr_raw) < THR_W'(top_q)) ? THR_W'(top_q) : THR_W'(thr_raw);
		thr_c      = (thr_lo > THR_W'(upper)) ? THR_W'(upper) : thr_lo;
		beat_w     = (THR_W'(sample_q) < thr_c) && (elapsed_q > TW'(refr_q));
	end

	// rate check and averaging bookkeeping
	always_comb begin
		rate_sat  = (|div_quot[N-1:RW]) ? {RW{1'b1}} : div_quot[RW-1:0];
		rate_ok   = (rate_sat > min_q) && (rate_sat < max_q);
		acc_next  = acc_q + ACC_W'(rate_sat);
		bad_next  = (bad_q == ecgrp_pkg::BAD_LIMIT) ? bad_q : bad_q + 2'd1;
		avg_full  = (cnt_q == CNT_LAST);
		havg_prod = avg_sum_q * HAVG_MUL;
	end

	// divider operands
	assign div_start    = (state_q == ST_CLAMP) && beat_w;
	assign div_dividend = tpm_q;
	assign div_divisor  = elapsed_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q      <= ecgrp_pkg::RST_WINDOW_TOP;
			height_q   <= ecgrp_pkg::RST_WINDOW_HEIGHT;
			refr_q     <= ecgrp_pkg::RST_REFRACTORY_TICKS;
			tpm_q      <= ecgrp_pkg::RST_TICKS_PER_MINUTE;
			min_q      <= ecgrp_pkg::RST_MIN_RATE;
			max_q      <= ecgrp_pkg::RST_MAX_RATE;
			nb_ticks_q <= ecgrp_pkg::RST_NO_BEAT_TICKS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ecgrp_pkg::REG_WINDOW_TOP:       top_q      <= cfg_data[9:0];
				ecgrp_pkg::REG_WINDOW_HEIGHT:    height_q   <= cfg_data[9:0];
				ecgrp_pkg::REG_REFRACTORY_TICKS: refr_q     <= cfg_data[15:0];
				ecgrp_pkg::REG_TICKS_PER_MINUTE: tpm_q      <= cfg_data[23:0];
				ecgrp_pkg::REG_MIN_RATE:         min_q      <= cfg_data[7:0];
				ecgrp_pkg::REG_MAX_RATE:         max_q      <= cfg_data[7:0];
				ecgrp_pkg::REG_NO_BEAT_TICKS:    nb_ticks_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			wrapped_q   <= 1'b0;
			sum_q       <= '0;
			last_beat_q <= '0;
			acc_q       <= '0;
			cnt_q       <= '0;
			bad_q       <= '0;
			rate_reg_q  <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					sum_q <= sum_next;
					if (idx_q == IDX_LAST) begin
						idx_q     <= '0;
						wrapped_q <= 1'b1;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
					state_q <= ST_AVG;
				end
				ST_AVG:   state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_TEN;
				ST_TEN:   state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= beat_w ? ST_RATE : ST_OUT;
				ST_RATE: begin
					if (div_stat.done) begin
						last_beat_q <= tick_q;
						if (rate_ok) begin
							bad_q <= '0;
							if (avg_full) begin
								acc_q   <= '0;
								cnt_q   <= '0;
								state_q <= ST_HAVG;
							end else begin
								acc_q   <= acc_next;
								cnt_q   <= cnt_q + CNT_W'(1);
								state_q <= ST_OUT;
							end
						end else begin
							bad_q <= bad_next;
							if (bad_next == ecgrp_pkg::BAD_LIMIT) begin
								rate_reg_q <= '0;
								acc_q      <= '0;
								cnt_q      <= '0;
							end
							state_q <= ST_OUT;
						end
					end
				end
				ST_HAVG: begin
					rate_reg_q <= havg_prod[HAVG_SHIFT +: RW];
					state_q    <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-sample datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= s_tdata[SAMPLE_BITS-1:0];
			tick_q   <= s_tdata[SAMPLE_BITS +: TW];
		end
		if (state_q == ST_SUM) begin
			elapsed_q <= tick_q - last_beat_q;
		end
		if (state_q == ST_AVG) begin
			prod_avg_q <= sum_q * AVG_MUL;
		end
		if (state_q == ST_SCALE) begin
			avg7_q <= {avg_w, 3'b000} - {3'b000, avg_w};
		end
		if (state_q == ST_TEN) begin
			prod_ten_q <= avg7_q * TEN_MUL;
		end
		if (state_q == ST_CLAMP) begin
			thr_q    <= thr_c[SAMPLE_BITS-1:0];
			beat_q   <= beat_w;
			ok_q     <= 1'b0;
			upd_q    <= 1'b0;
			nobeat_q <= !beat_w && (elapsed_q > nb_ticks_q);
		end
		if ((state_q == ST_RATE) && div_stat.done) begin
			ok_q      <= rate_ok;
			upd_q     <= rate_ok ? avg_full : (bad_next == ecgrp_pkg::BAD_LIMIT);
			avg_sum_q <= acc_next;
		end
		if (out_load) begin
			m_tdata_q <= OUT_W'({nobeat_q, rate_reg_q, upd_q, ok_q, beat_q, thr_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_ram_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> !accept)
		else $error("ring read and write overlap");

	a_update_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[SAMPLE_BITS+2] || m_tdata[SAMPLE_BITS+1]))
		|-> m_tdata[SAMPLE_BITS])
		else $error("rate flags without beat");

	a_beat_excl_nobeat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[SAMPLE_BITS]) |-> !m_tdata[SAMPLE_BITS+RW+3])
		else $error("beat and no_beat together");

endmodule
